/* src/stst_pkg.sv */
// ----------------------------------------------------------------------------
// stst_pkg: shared types and constants for the scored target select tracker
// Score formats, result codes and the result record pushed to the output queue.
// ----------------------------------------------------------------------------
package stst_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int SCORE_W     = 32;
  localparam int ID_W        = 32;
  localparam int STATUS_W    = 8;
  localparam int MIN_W       = 9;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_THR = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIRT_SEC   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT  = 4'd3;

  // reset values, Q16.16
  localparam logic signed [SCORE_W-1:0] SCORE_THR_RST  = -32'sd282;
  localparam logic signed [SCORE_W-1:0] MARGIN_THR_RST = 32'sd983;
  localparam logic signed [SCORE_W-1:0] VIRT_SEC_RST   = -32'sd282;
  localparam logic [MIN_W-1:0]          MIN_COUNT_RST  = 9'd2;

  localparam logic [STATUS_W-1:0] STATUS_SCORED = 8'd0;

  typedef enum logic [1:0] {
    TS_SEARCHING = 2'd0,
    TS_TRACKING  = 2'd1,
    TS_LOST      = 2'd2
  } tstate_t;

  typedef enum logic [2:0] {
    RC_SELECTED    = 3'd0,
    RC_RESELECTED  = 3'd1,
    RC_REJECTED    = 3'd2,
    RC_MISSING     = 3'd3,
    RC_NONE_PASSED = 3'd4
  } reason_t;

  typedef struct packed {
    tstate_t                     state;
    logic [ID_W-1:0]             id;
    logic signed [SCORE_W-1:0]   score;
    reason_t                     reason;
    logic                        last;
  } result_t;

endpackage

/* src/scored_target_select_tracker_top.sv */
// ----------------------------------------------------------------------------
// scored_target_select_tracker_top: best-of-batch target selection and tracking
// Tracks best/second score over a batch of entries and decides on the last one.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------------
//  in      | input     | in_valid/in_stall   | entry_id entry_score score_ok
//          |           |                     | entry_status batch_last
//  out     | output    | out_valid/out_stall | track_state target_id target_score
//          |           |                     | reason_code result_last
//  cfg     | input     | cfg_we              | cfg_index cfg_data
//
// One entry per cycle unless in_stall holds it: a request is registered, then the tracker update and, on
// the last entry, the decision run combinationally into a 4-deep result queue.
// A request passes through the input register and then the result queue.
// A last entry waits in the input register until the queue has two free slots.
// Reset (rst, synchronous) clears the batch, the active target and the queue,
// and loads the register reset values.
module scored_target_select_tracker_top
  import stst_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [ID_W-1:0]              entry_id,
  input  logic signed [SCORE_W-1:0]    entry_score,
  input  logic                         score_ok,
  input  logic [STATUS_W-1:0]          entry_status,
  input  logic                         batch_last,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   track_state,
  output logic [ID_W-1:0]              target_id,
  output logic signed [SCORE_W-1:0]    target_score,
  output logic [2:0]                   reason_code,
  output logic                         result_last
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // configuration
  logic signed [SCORE_W-1:0] score_thr;
  logic signed [SCORE_W-1:0] margin_thr;
  logic signed [SCORE_W-1:0] virt_sec;
  logic [MIN_W-1:0]          min_count;

  // input register
  logic                      iv;
  logic [ID_W-1:0]           i_id;
  logic signed [SCORE_W-1:0] i_score;
  logic                      i_counts;
  logic                      i_last;

  // batch and target state
  logic [ID_W-1:0]           active_id;
  logic signed [SCORE_W-1:0] best_score;
  logic [ID_W-1:0]           best_id;
  logic signed [SCORE_W-1:0] runner_score;
  logic [CNT_W-1:0]          counted;
  logic                      seen;
  logic signed [SCORE_W-1:0] seen_score;

  logic [ID_W-1:0]           active_id_next;
  logic signed [SCORE_W-1:0] best_score_next;
  logic [ID_W-1:0]           best_id_next;
  logic signed [SCORE_W-1:0] runner_score_next;
  logic [CNT_W-1:0]          counted_next;
  logic                      seen_next;
  logic signed [SCORE_W-1:0] seen_score_next;

  // result queue
  result_t                   q [QDEPTH];
  logic [QPTR_W-1:0]         wp;
  logic [QPTR_W-1:0]         rp;
  logic [QCNT_W-1:0]         qcnt;

  logic                      proc;
  logic                      in_accept;
  logic                      pop;
  logic                      push0;
  logic                      push1;
  result_t                   r0;
  result_t                   r1;
  logic [QCNT_W-1:0]         npush;

  logic                      had_one;
  logic signed [SCORE_W-1:0] sec_use;
  logic signed [SCORE_W:0]   margin;
  logic                      sel;
  logic signed [SCORE_W-1:0] act_score;
  logic                      drop;

  assign proc      = iv && (!i_last || (qcnt <= QCNT_W'(QDEPTH - 2)));
  assign in_stall  = iv && !proc;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = (qcnt != '0);
  assign pop       = out_valid && !out_stall;

  assign track_state  = q[rp].state;
  assign target_id    = q[rp].id;
  assign target_score = q[rp].score;
  assign reason_code  = q[rp].reason;
  assign result_last  = q[rp].last;

  always_comb begin
    best_score_next   = best_score;
    best_id_next      = best_id;
    runner_score_next = runner_score;
    counted_next      = counted;
    seen_next         = seen;
    seen_score_next   = seen_score;
    active_id_next    = active_id;
    push0             = 1'b0;
    push1             = 1'b0;
    r0                = '{TS_SEARCHING, '0, '0, RC_NONE_PASSED, 1'b1};
    r1                = '{TS_TRACKING, '0, '0, RC_RESELECTED, 1'b1};
    had_one           = (counted != '0);

    if (i_counts) begin
      // ties keep the earlier entry as best
      if (!had_one || (i_score > best_score)) begin
        if (had_one) begin
          runner_score_next = best_score;
        end
        best_score_next = i_score;
        best_id_next    = i_id;
      end else if ((counted == CNT_W'(1)) || (i_score > runner_score)) begin
        runner_score_next = i_score;
      end
      if (counted < CNT_W'(MAX_ENTRIES)) begin
        counted_next = counted + CNT_W'(1);
      end
      if ((active_id != '0) && (i_id == active_id) && !seen) begin
        seen_next       = 1'b1;
        seen_score_next = i_score;
      end
    end

    sec_use   = (counted_next > CNT_W'(1)) ? runner_score_next : virt_sec;
    margin    = {best_score_next[SCORE_W-1], best_score_next} -
                {sec_use[SCORE_W-1], sec_use};
    sel       = (counted_next != '0) &&
                (32'(counted_next) >= 32'(min_count)) &&
                (best_score_next > score_thr) &&
                (margin >= $signed({margin_thr[SCORE_W-1], margin_thr}));
    act_score = seen_score_next;
    drop      = !seen_next || (act_score <= score_thr);

    if (i_last) begin
      if (active_id == '0) begin
        push0 = 1'b1;
        if (sel) begin
          r0             = '{TS_TRACKING, best_id_next, best_score_next, RC_SELECTED, 1'b1};
          active_id_next = best_id_next;
        end
      end else if (drop) begin
        push0 = 1'b1;
        r0    = '{TS_LOST, active_id, '0, (seen_next ? RC_REJECTED : RC_MISSING), !sel};
        if (sel) begin
          push1          = 1'b1;
          r1             = '{TS_TRACKING, best_id_next, best_score_next, RC_RESELECTED, 1'b1};
          active_id_next = best_id_next;
        end else begin
          active_id_next = '0;
        end
      end
      // new batch
      counted_next = '0;
      seen_next    = 1'b0;
    end

    if (!proc) begin
      push0 = 1'b0;
      push1 = 1'b0;
    end
    npush = QCNT_W'(push0) + QCNT_W'(push1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      score_thr  <= SCORE_THR_RST;
      margin_thr <= MARGIN_THR_RST;
      virt_sec   <= VIRT_SEC_RST;
      min_count  <= MIN_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCORE_THR:  score_thr  <= cfg_data;
        CFG_MARGIN_THR: margin_thr <= cfg_data;
        CFG_VIRT_SEC:   virt_sec   <= cfg_data;
        CFG_MIN_COUNT:  min_count  <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      i_id     <= entry_id;
      i_score  <= entry_score;
      i_counts <= score_ok && (entry_status == STATUS_SCORED);
      i_last   <= batch_last;
    end
    if (proc) begin
      best_score   <= best_score_next;
      best_id      <= best_id_next;
      runner_score <= runner_score_next;
      seen_score   <= seen_score_next;
    end
    if (push0) begin
      q[wp] <= r0;
    end
    if (push1) begin
      q[wp + QPTR_W'(1)] <= r1;
    end
    if (rst) begin
      iv        <= 1'b0;
      active_id <= '0;
      counted   <= '0;
      seen      <= 1'b0;
      wp        <= '0;
      rp        <= '0;
      qcnt      <= '0;
    end else begin
      if (in_accept) begin
        iv <= 1'b1;
      end else if (proc) begin
        iv <= 1'b0;
      end
      if (proc) begin
        active_id <= active_id_next;
        counted   <= counted_next;
        seen      <= seen_next;
      end
      wp   <= wp + QPTR_W'(npush);
      rp   <= rp + QPTR_W'(pop);
      qcnt <= qcnt + npush - QCNT_W'(pop);
    end
  end

  a_qcnt_bound: assert property (@(posedge clk) disable iff (rst)
    qcnt <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    counted <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above limit");

  a_active_hold: assert property (@(posedge clk) disable iff (rst)
    !(proc && i_last) |=> $stable(active_id))
    else $error("active target changed outside a decision");

  a_second_push: assert property (@(posedge clk) disable iff (rst)
    push1 |-> (push0 && (r0.state == TS_LOST) && !r0.last))
    else $error("reselect without a preceding lost result");

endmodule
